// ===== hw/rtl/pcl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcl_pkg
// shared types, constants and helpers of the pad proximity clustering block
// ----------------------------------------------------------------------------
package pcl_pkg;

    localparam int MAX_PADS_DEF = 64;
    localparam int MARGIN_W     = 10;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd8;

    // one stored pad, packed low to high as x, y, width, height
    typedef struct packed {
        logic [14:0] height;
        logic [14:0] width;
        logic [15:0] y;
        logic [15:0] x;
    } pad_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEED,
        ST_SCAN,
        ST_PIVOT,
        ST_SWEEP,
        ST_DONE
    } st_t;

    // sign extend a 16-bit coordinate to 18 bits
    function automatic logic signed [17:0] ext18(input logic [15:0] v);
        ext18 = $signed({{2{v[15]}}, v});
    endfunction

    // coordinate plus extent, 17-bit signed
    function automatic logic signed [16:0] pad_end(input logic [15:0] s,
                                                   input logic [14:0] e);
        pad_end = $signed({s[15], s}) + $signed({2'b00, e});
    endfunction

endpackage

// ===== hw/rtl/pad_proximity_clustering.sv =====
// ----------------------------------------------------------------------------
// pad_proximity_clustering
// groups rectangular pads into proximity clusters and reports their boxes
// ----------------------------------------------------------------------------
// usage:
//  - pads come in on the s_ stream, one request per pad, one per cycle while
//    loading; s_tlast marks the final pad of a board and starts clustering
//  - pads beyond MAX_PADS are dropped; every cluster of that board then
//    carries pads_dropped in m_tuser
//  - one result request per cluster leaves on the m_ stream, m_tlast on the
//    final cluster of the board; clusters are seeded from the highest index
//  - each frontier pad costs a scan for the next frontier bit, one pivot
//    read and a sweep of all n pads through the single memory read port,
//    besides the seed steps; that read port bounds the clustering time
//  - s_tready is low while clustering; it rises again once the final cluster
//    sits in the output register, so the next board may load while it waits
//  - a stalled m_tready holds the current result; clustering runs on and
//    waits in its done step until the output register frees
//  - reset empties the board, clears the output and sets the margin to 8
//  - cfg_ is to be written by the user only while the block is idle; the
//    block itself does not enforce this; cfg_ready is always high
// ----------------------------------------------------------------------------
module pad_proximity_clustering #(
    parameter int MAX_PADS = pcl_pkg::MAX_PADS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // pad stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // pad_x[15:0], pad_y[31:16], pad_width[46:32],
                                    // pad_height[61:47], zero fill
    input  logic        s_tlast,    // last_pad
    // cluster stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // box_left[15:0], box_bottom[31:16],
                                    // box_right[48:32], box_top[65:49],
                                    // member_count[72:66], zero fill
    output logic        m_tlast,    // last_cluster
    output logic        m_tuser,    // pads_dropped
    // margin register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pcl_pkg::MARGIN_W-1:0] cfg_data
);

    localparam int IW = (MAX_PADS > 1) ? $clog2(MAX_PADS) : 1;
    localparam int CW = $clog2(MAX_PADS + 1);

    // control state
    pcl_pkg::st_t                   state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;       // pads on the board
    logic                           ovf_reg, ovf_next;
    logic [MAX_PADS-1:0]            assigned_reg, assigned_next;
    logic [MAX_PADS-1:0]            frontier_reg, frontier_next;
    logic [CW-1:0]                  asg_cnt_reg, asg_cnt_next;   // pads in any cluster
    logic [CW-1:0]                  fr_cnt_reg, fr_cnt_next;     // pads in the frontier
    logic [IW-1:0]                  seed_reg, seed_next;
    logic [IW-1:0]                  scan_reg, scan_next;
    logic [IW-1:0]                  sweep_reg, sweep_next;
    logic [pcl_pkg::MARGIN_W-1:0]   margin_reg;
    logic                           out_valid_reg, out_valid_next;

    // payload
    logic signed [15:0]             left_reg, bottom_reg;
    logic signed [16:0]             right_reg, top_reg;
    logic [CW-1:0]                  mcnt_reg, mcnt_next;
    logic [79:0]                    out_data_reg;
    logic                           out_last_reg;
    logic                           out_drop_reg;

    // datapath controls
    logic                           in_acc;
    logic                           wr_en;
    logic [IW-1:0]                  rd_addr;
    logic                           pivot_load;
    logic                           out_load;
    logic                           board_done;
    logic [CW-1:0]                  n_new;
    logic [CW-1:0]                  last_cw;
    logic [IW-1:0]                  last_idx;

    pcl_pkg::pad_t                  in_pad;
    pcl_pkg::pad_t                  rd_pad;
    logic                           near;
    logic signed [16:0]             piv_right;
    logic signed [16:0]             piv_top;

    assign in_pad.x      = s_tdata[15:0];
    assign in_pad.y      = s_tdata[31:16];
    assign in_pad.width  = s_tdata[46:32];
    assign in_pad.height = s_tdata[61:47];

    assign s_tready  = (state_reg == pcl_pkg::ST_LOAD);
    assign in_acc    = s_tvalid && s_tready;
    assign wr_en     = in_acc && (count_reg < CW'(MAX_PADS));
    assign cfg_ready = 1'b1;

    assign last_cw  = count_reg - CW'(1);
    assign last_idx = last_cw[IW-1:0];

    pcl_pad_mem #(
        .MAX_PADS (MAX_PADS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (in_pad),
        .rd_addr (rd_addr),
        .rd_data (rd_pad)
    );

    pcl_near_unit u_near (
        .clk    (clk),
        .load   (pivot_load),
        .pivot  (rd_pad),
        .cand   (rd_pad),
        .margin (margin_reg),
        .near   (near)
    );

    assign piv_right = pcl_pkg::pad_end(rd_pad.x, rd_pad.width);
    assign piv_top   = pcl_pkg::pad_end(rd_pad.y, rd_pad.height);

    // next state and controls
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        assigned_next  = assigned_reg;
        frontier_next  = frontier_reg;
        asg_cnt_next   = asg_cnt_reg;
        fr_cnt_next    = fr_cnt_reg;
        seed_next      = seed_reg;
        scan_next      = scan_reg;
        sweep_next     = sweep_reg;
        mcnt_next      = mcnt_reg;
        rd_addr        = scan_reg;
        pivot_load     = 1'b0;
        out_load       = 1'b0;
        board_done     = (asg_cnt_reg == count_reg);
        n_new          = (count_reg < CW'(MAX_PADS)) ? count_reg + CW'(1) : count_reg;

        case (state_reg)
            pcl_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    count_next = n_new;
                    if (!wr_en)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        seed_next  = IW'(n_new - CW'(1));
                        state_next = pcl_pkg::ST_SEED;
                    end
                end
            end

            // walk down to the highest pad not yet in a cluster
            pcl_pkg::ST_SEED:
            begin
                if (!assigned_reg[seed_reg])
                begin
                    assigned_next[seed_reg] = 1'b1;
                    frontier_next[seed_reg] = 1'b1;
                    asg_cnt_next = asg_cnt_reg + CW'(1);
                    fr_cnt_next  = CW'(1);
                    mcnt_next    = '0;
                    scan_next    = seed_reg;
                    state_next   = pcl_pkg::ST_SCAN;
                end
                else
                begin
                    seed_next = seed_reg - IW'(1);
                end
            end

            // look for the next frontier pad, wrapping at the board size
            pcl_pkg::ST_SCAN:
            begin
                if (fr_cnt_reg == '0)
                begin
                    state_next = pcl_pkg::ST_DONE;
                end
                else if (frontier_reg[scan_reg])
                begin
                    frontier_next[scan_reg] = 1'b0;
                    fr_cnt_next = fr_cnt_reg - CW'(1);
                    rd_addr     = scan_reg;
                    state_next  = pcl_pkg::ST_PIVOT;
                end
                else
                begin
                    scan_next = (scan_reg == last_idx) ? '0 : scan_reg + IW'(1);
                end
            end

            // pivot data is out of the memory: latch it, grow the box
            pcl_pkg::ST_PIVOT:
            begin
                pivot_load = 1'b1;
                mcnt_next  = mcnt_reg + CW'(1);
                rd_addr    = '0;
                sweep_next = '0;
                state_next = pcl_pkg::ST_SWEEP;
            end

            // one candidate per cycle against the pivot
            pcl_pkg::ST_SWEEP:
            begin
                rd_addr = sweep_reg + IW'(1);
                if (!assigned_reg[sweep_reg] && near)
                begin
                    assigned_next[sweep_reg] = 1'b1;
                    frontier_next[sweep_reg] = 1'b1;
                    asg_cnt_next = asg_cnt_reg + CW'(1);
                    fr_cnt_next  = fr_cnt_reg + CW'(1);
                end
                if (sweep_reg == last_idx)
                begin
                    state_next = pcl_pkg::ST_SCAN;
                end
                else
                begin
                    sweep_next = sweep_reg + IW'(1);
                end
            end

            // hand the cluster to the output register once it is free
            pcl_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if (board_done)
                    begin
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        assigned_next = '0;
                        asg_cnt_next  = '0;
                        state_next    = pcl_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = pcl_pkg::ST_SEED;
                    end
                end
            end

            default:
            begin
                state_next = pcl_pkg::ST_LOAD;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcl_pkg::ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            assigned_reg  <= '0;
            frontier_reg  <= '0;
            asg_cnt_reg   <= '0;
            fr_cnt_reg    <= '0;
            seed_reg      <= '0;
            scan_reg      <= '0;
            sweep_reg     <= '0;
            mcnt_reg      <= '0;
            margin_reg    <= pcl_pkg::MARGIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            assigned_reg  <= assigned_next;
            frontier_reg  <= frontier_next;
            asg_cnt_reg   <= asg_cnt_next;
            fr_cnt_reg    <= fr_cnt_next;
            seed_reg      <= seed_next;
            scan_reg      <= scan_next;
            sweep_reg     <= sweep_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                margin_reg <= cfg_data;
            end
        end
    end

    // bounding box and output payload
    always_ff @(posedge clk)
    begin
        if (pivot_load)
        begin
            if (mcnt_reg == '0)
            begin
                left_reg   <= $signed(rd_pad.x);
                bottom_reg <= $signed(rd_pad.y);
                right_reg  <= piv_right;
                top_reg    <= piv_top;
            end
            else
            begin
                if ($signed(rd_pad.x) < left_reg)
                begin
                    left_reg <= $signed(rd_pad.x);
                end
                if ($signed(rd_pad.y) < bottom_reg)
                begin
                    bottom_reg <= $signed(rd_pad.y);
                end
                if (piv_right > right_reg)
                begin
                    right_reg <= piv_right;
                end
                if (piv_top > top_reg)
                begin
                    top_reg <= piv_top;
                end
            end
        end
        if (out_load)
        begin
            out_data_reg <= {7'b0, 7'(mcnt_reg), top_reg, right_reg, bottom_reg, left_reg};
            out_last_reg <= board_done;
            out_drop_reg <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_drop_reg;

endmodule

// ===== hw/rtl/pcl_pad_mem.sv =====
// ----------------------------------------------------------------------------
// pcl_pad_mem
// pad store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module pcl_pad_mem #(
    parameter int MAX_PADS = pcl_pkg::MAX_PADS_DEF
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_PADS)-1:0] wr_addr,
    input  pcl_pkg::pad_t               wr_data,
    input  logic [$clog2(MAX_PADS)-1:0] rd_addr,
    output pcl_pkg::pad_t               rd_data
);

    pcl_pkg::pad_t mem [MAX_PADS];
    pcl_pkg::pad_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/pcl_near_unit.sv =====
// ----------------------------------------------------------------------------
// pcl_near_unit
// holds the pivot pad and tests one candidate pad per cycle for nearness
// ----------------------------------------------------------------------------
module pcl_near_unit (
    input  logic                           clk,
    input  logic                           load,
    input  pcl_pkg::pad_t                  pivot,
    input  pcl_pkg::pad_t                  cand,
    input  logic [pcl_pkg::MARGIN_W-1:0]   margin,
    output logic                           near
);

    logic signed [17:0] piv_x_reg;
    logic signed [17:0] piv_y_reg;
    logic signed [17:0] piv_xe_reg;   // pivot right edge plus margin
    logic signed [17:0] piv_ye_reg;   // pivot top edge plus margin
    logic signed [17:0] piv_xm_reg;   // pivot left edge minus margin
    logic signed [17:0] piv_ym_reg;   // pivot bottom edge minus margin

    logic signed [17:0] margin_s;
    logic signed [17:0] cand_x;
    logic signed [17:0] cand_y;
    logic signed [17:0] cand_xe;
    logic signed [17:0] cand_ye;
    logic               near_x;
    logic               near_y;

    assign margin_s = $signed({8'b0, margin});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            piv_x_reg  <= pcl_pkg::ext18(pivot.x);
            piv_y_reg  <= pcl_pkg::ext18(pivot.y);
            piv_xe_reg <= pcl_pkg::ext18(pivot.x) + $signed({3'b000, pivot.width}) + margin_s;
            piv_ye_reg <= pcl_pkg::ext18(pivot.y) + $signed({3'b000, pivot.height}) + margin_s;
            piv_xm_reg <= pcl_pkg::ext18(pivot.x) - margin_s;
            piv_ym_reg <= pcl_pkg::ext18(pivot.y) - margin_s;
        end
    end

    always_comb
    begin
        cand_x  = pcl_pkg::ext18(cand.x);
        cand_y  = pcl_pkg::ext18(cand.y);
        cand_xe = cand_x + $signed({3'b000, cand.width});
        cand_ye = cand_y + $signed({3'b000, cand.height});
        // whichever pad starts first must reach the other within the margin
        if (piv_x_reg < cand_x)
        begin
            near_x = (piv_xe_reg >= cand_x);
        end
        else
        begin
            near_x = (cand_xe >= piv_xm_reg);
        end
        if (piv_y_reg < cand_y)
        begin
            near_y = (piv_ye_reg >= cand_y);
        end
        else
        begin
            near_y = (cand_ye >= piv_ym_reg);
        end
        near = near_x && near_y;
    end

endmodule
